FILE: design/lsh_pkg.sv
// Shared types, widths and codes for the Laplacian sharpen block.
package lsh_pkg;

    localparam int unsigned MAX_LINE_SAMPLES_DEF = 8192;
    localparam int unsigned MAX_CHANNELS_DEF     = 4;

    localparam int unsigned SAMPLE_W   = 8;
    localparam int unsigned DIM_W      = 12;
    localparam int unsigned ROW_W      = 11;
    localparam int unsigned RAW_CH_W   = 3;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH   = 2'd0,
        REG_IMAGE_HEIGHT  = 2'd1,
        REG_CHANNEL_COUNT = 2'd2
    } t_reg_idx;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    typedef struct packed {
        logic                command;
        logic [SAMPLE_W-1:0] sample;
    } t_in_beat;

    typedef struct packed {
        logic [SAMPLE_W-1:0] result_value;
        logic                frame_last;
    } t_out_beat;

    // One line store entry: the sample as it arrived and the window centre of that beat.
    typedef struct packed {
        logic [SAMPLE_W-1:0] fresh;
        logic [SAMPLE_W-1:0] centre;
    } t_line_word;

    typedef struct packed {
        logic emit;
        logic interior;
        logic frame_last;
    } t_emit_ctrl;

endpackage

FILE: design/lsh_cfg.sv
// Configuration registers and the clamped frame geometry derived from them.
module lsh_cfg
    import lsh_pkg::*;
#(
    parameter int unsigned MAX_LINE_SAMPLES = MAX_LINE_SAMPLES_DEF,
    parameter int unsigned MAX_CHANNELS     = MAX_CHANNELS_DEF,
    localparam int unsigned CH_W  = $clog2(MAX_CHANNELS + 1),
    localparam int unsigned LEN_W = $clog2(MAX_LINE_SAMPLES + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_valid,
    input  logic [CFG_IDX_W-1:0]  i_wr_index,
    input  logic [CFG_DATA_W-1:0] i_wr_data,
    output logic                  o_clear,
    output logic [CH_W-1:0]       o_eff_ch,
    output logic [DIM_W-1:0]      o_eff_h,
    output logic [LEN_W-1:0]      o_line_len
);

    localparam int unsigned PROD_W = LEN_W + CH_W;

    localparam logic [DIM_W-1:0]    DIM_MIN     = DIM_W'(3);
    localparam logic [DIM_W-1:0]    DIM_MAX     = DIM_W'(2048);
    localparam logic [DIM_W-1:0]    WIDTH_RST   = DIM_W'(640);
    localparam logic [DIM_W-1:0]    HEIGHT_RST  = DIM_W'(480);
    localparam logic [RAW_CH_W-1:0] CHAN_RST    = RAW_CH_W'(3);

    localparam int unsigned RST_CH    = (3 > MAX_CHANNELS) ? MAX_CHANNELS : 3;
    localparam int unsigned RST_W_LIM = MAX_LINE_SAMPLES / RST_CH;
    localparam int unsigned RST_W     = (640 > RST_W_LIM) ? RST_W_LIM : 640;
    localparam int unsigned RST_LEN   = RST_W * RST_CH;

    localparam logic [LEN_W-1:0] LIM1 = LEN_W'(MAX_LINE_SAMPLES);
    localparam logic [LEN_W-1:0] LIM2 = LEN_W'(MAX_LINE_SAMPLES / 2);
    localparam logic [LEN_W-1:0] LIM3 = LEN_W'(MAX_LINE_SAMPLES / 3);
    localparam logic [LEN_W-1:0] LIM4 = LEN_W'(MAX_LINE_SAMPLES / 4);

    logic [DIM_W-1:0]    r_width;
    logic [DIM_W-1:0]    r_height;
    logic [RAW_CH_W-1:0] r_chan;

    logic [CH_W-1:0]   r_eff_ch;
    logic [DIM_W-1:0]  r_eff_h;
    logic [LEN_W-1:0]  r_line_len;

    logic [CH_W-1:0]   n_eff_ch;
    logic [DIM_W-1:0]  n_eff_h;
    logic [LEN_W-1:0]  n_line_len;
    logic [DIM_W-1:0]  w_clamped;
    logic [LEN_W-1:0]  w_lim;
    logic [LEN_W-1:0]  w_eff;
    logic [PROD_W-1:0] w_prod;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        if (v < DIM_MIN) begin
            return DIM_MIN;
        end else if (v > DIM_MAX) begin
            return DIM_MAX;
        end
        return v;
    endfunction

    assign o_clear = i_wr_valid && (i_wr_index == REG_IMAGE_WIDTH ||
                                    i_wr_index == REG_IMAGE_HEIGHT ||
                                    i_wr_index == REG_CHANNEL_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_chan   <= CHAN_RST;
        end else if (i_wr_valid) begin
            case (i_wr_index)
                REG_IMAGE_WIDTH:   r_width  <= i_wr_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT:  r_height <= i_wr_data[DIM_W-1:0];
                REG_CHANNEL_COUNT: r_chan   <= i_wr_data[RAW_CH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_chan == '0) begin
            n_eff_ch = CH_W'(1);
        end else if (32'(r_chan) > MAX_CHANNELS) begin
            n_eff_ch = CH_W'(MAX_CHANNELS);
        end else begin
            n_eff_ch = CH_W'(r_chan);
        end

        if (32'(n_eff_ch) == 1) begin
            w_lim = LIM1;
        end else if (32'(n_eff_ch) == 2) begin
            w_lim = LIM2;
        end else if (32'(n_eff_ch) == 3) begin
            w_lim = LIM3;
        end else begin
            w_lim = LIM4;
        end

        w_clamped = clamp_dim(r_width);
        if (32'(w_clamped) > 32'(w_lim)) begin
            w_eff = w_lim;
        end else begin
            w_eff = LEN_W'(w_clamped);
        end

        w_prod     = PROD_W'(w_eff) * PROD_W'(n_eff_ch);
        n_line_len = w_prod[LEN_W-1:0];
        n_eff_h    = clamp_dim(r_height);
    end

    // The clamped geometry is registered behind the configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_ch   <= CH_W'(RST_CH);
            r_eff_h    <= HEIGHT_RST;
            r_line_len <= LEN_W'(RST_LEN);
        end else begin
            r_eff_ch   <= n_eff_ch;
            r_eff_h    <= n_eff_h;
            r_line_len <= n_line_len;
        end
    end

    assign o_eff_ch   = r_eff_ch;
    assign o_eff_h    = r_eff_h;
    assign o_line_len = r_line_len;

endmodule

FILE: design/lsh_line_mem.sv
// Circular line store: one write port, one registered read port.
module lsh_line_mem
    import lsh_pkg::*;
#(
    parameter int unsigned DEPTH = MAX_LINE_SAMPLES_DEF,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_line_word    o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_line_word    i_wr_data
);

    t_line_word r_mem [DEPTH];
    t_line_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/lsh_kernel.sv
// Neighbour delay taps and the cross-kernel sum with saturation.
module lsh_kernel
    import lsh_pkg::*;
#(
    parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF,
    localparam int unsigned CH_W = $clog2(MAX_CHANNELS + 1)
) (
    input  logic                i_clk,
    input  logic                i_shift,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  t_line_word          i_line,
    input  logic [CH_W-1:0]     i_eff_ch,
    output logic [SAMPLE_W-1:0] o_value,
    output logic [SAMPLE_W-1:0] o_centre
);

    localparam int unsigned DIDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int unsigned MID_N  = 2 * MAX_CHANNELS;
    localparam int unsigned EIDX_W = $clog2(MID_N);
    localparam int unsigned ACC_W  = SAMPLE_W + 4;
    localparam logic signed [ACC_W-1:0] GAIN    = ACC_W'(5);
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(255);

    // r_down[k] holds the sample k+1 beats back; r_mid[k] the line-delayed one k+1 back.
    logic [SAMPLE_W-1:0] r_down [MAX_CHANNELS];
    logic [SAMPLE_W-1:0] r_mid  [MID_N];

    logic [CH_W-1:0]          ch_m1;
    logic [CH_W:0]            ch_x2_m1;
    logic [CH_W:0]            ch_m1_x;
    logic [SAMPLE_W-1:0]      tap_down;
    logic [SAMPLE_W-1:0]      tap_left;
    logic [SAMPLE_W-1:0]      tap_centre;
    logic signed [ACC_W-1:0]  acc;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_down[0] <= i_sample;
            for (int k = 1; k < MAX_CHANNELS; k++) begin
                r_down[k] <= r_down[k-1];
            end
            r_mid[0] <= i_line.fresh;
            for (int k = 1; k < MID_N; k++) begin
                r_mid[k] <= r_mid[k-1];
            end
        end
    end

    assign ch_m1    = i_eff_ch - CH_W'(1);
    assign ch_m1_x  = {1'b0, ch_m1};
    assign ch_x2_m1 = {i_eff_ch, 1'b0} - (CH_W + 1)'(1);

    assign tap_down   = r_down[ch_m1[DIDX_W-1:0]];
    assign tap_centre = r_mid[ch_m1_x[EIDX_W-1:0]];
    assign tap_left   = r_mid[ch_x2_m1[EIDX_W-1:0]];

    always_comb begin
        acc = GAIN * $signed(ACC_W'(tap_centre))
            - $signed(ACC_W'(tap_left))
            - $signed(ACC_W'(i_line.fresh))
            - $signed(ACC_W'(i_line.centre))
            - $signed(ACC_W'(tap_down));
        if (acc < 0) begin
            o_value = '0;
        end else if (acc > SAT_MAX) begin
            o_value = '1;
        end else begin
            o_value = acc[SAMPLE_W-1:0];
        end
    end

    assign o_centre = tap_centre;

endmodule

FILE: design/lsh_ctrl.sv
// Input and output raster positions, pending count and the emit decision.
module lsh_ctrl
    import lsh_pkg::*;
#(
    parameter int unsigned MAX_LINE_SAMPLES = MAX_LINE_SAMPLES_DEF,
    parameter int unsigned MAX_CHANNELS     = MAX_CHANNELS_DEF,
    localparam int unsigned CH_W  = $clog2(MAX_CHANNELS + 1),
    localparam int unsigned LEN_W = $clog2(MAX_LINE_SAMPLES + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clear,
    input  logic              i_fire,
    input  logic              i_command,
    input  logic [CH_W-1:0]   i_eff_ch,
    input  logic [DIM_W-1:0]  i_eff_h,
    input  logic [LEN_W-1:0]  i_line_len,
    output t_emit_ctrl        o_emit
);

    localparam int unsigned COL_W  = $clog2(MAX_LINE_SAMPLES);
    localparam int unsigned PEND_W = $clog2(MAX_LINE_SAMPLES + MAX_CHANNELS + 1);

    logic [COL_W-1:0]  r_in_col;
    logic [ROW_W-1:0]  r_in_row;
    logic [COL_W-1:0]  r_out_col;
    logic [ROW_W-1:0]  r_out_row;
    logic [PEND_W-1:0] r_pending;

    logic [PEND_W-1:0] n_pending;
    logic [PEND_W-1:0] lag;
    logic              is_sample;
    logic              in_behind;
    logic              emit;
    logic              in_col_wrap;
    logic              in_row_wrap;
    logic              out_col_wrap;
    logic              out_row_wrap;
    logic [DIM_W-1:0]  out_row_p1;
    logic [LEN_W-1:0]  out_col_p1;
    logic [LEN_W:0]    out_col_right;

    assign is_sample = (i_command == CMD_SAMPLE);
    assign lag       = PEND_W'(i_line_len) + PEND_W'(i_eff_ch);
    // The input has wrapped into the next frame ahead of the output.
    assign in_behind = (r_in_row < r_out_row) ||
                       (r_in_row == r_out_row && r_in_col < r_out_col);
    assign emit      = is_sample ? (r_pending >= lag) : in_behind;
    assign n_pending = r_pending + PEND_W'(is_sample) - PEND_W'(emit);

    assign in_col_wrap  = (LEN_W'(r_in_col) + LEN_W'(1)) >= i_line_len;
    assign in_row_wrap  = ({1'b0, r_in_row} + DIM_W'(1)) >= i_eff_h;
    assign out_col_p1   = LEN_W'(r_out_col) + LEN_W'(1);
    assign out_row_p1   = {1'b0, r_out_row} + DIM_W'(1);
    assign out_col_wrap = out_col_p1 >= i_line_len;
    assign out_row_wrap = out_row_p1 >= i_eff_h;
    assign out_col_right = (LEN_W + 1)'(r_out_col) + (LEN_W + 1)'(i_eff_ch);

    assign o_emit.emit       = emit;
    assign o_emit.interior   = (r_out_row != '0) && (out_row_p1 < i_eff_h) &&
                               (LEN_W'(r_out_col) >= LEN_W'(i_eff_ch)) &&
                               (out_col_right < (LEN_W + 1)'(i_line_len));
    assign o_emit.frame_last = (out_row_p1 == i_eff_h) && (out_col_p1 == i_line_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_pending <= '0;
        end else if (i_fire) begin
            r_pending <= n_pending;
            if (is_sample) begin
                if (in_col_wrap) begin
                    r_in_col <= '0;
                    r_in_row <= in_row_wrap ? '0 : r_in_row + ROW_W'(1);
                end else begin
                    r_in_col <= r_in_col + COL_W'(1);
                end
            end
            if (emit) begin
                if (out_col_wrap) begin
                    r_out_col <= '0;
                    r_out_row <= out_row_wrap ? '0 : r_out_row + ROW_W'(1);
                end else begin
                    r_out_col <= r_out_col + COL_W'(1);
                end
            end
        end
    end

endmodule

FILE: design/laplacian_sharpen_3x3.sv
// A beat that produces a result passes the stage 1 register and then the result register to o_out_data.
// Throughput: one beat per cycle, sample or flush, unless the output stalls; one line store read and write.
// Results lag samples by one line plus one pixel; flush beats drain the trailing border outputs.
// Reset (i_rst_n low, synchronous): registers to 640x480x3, positions and pipeline cleared.
// The line store is not cleared; unwritten entries only ever feed border outputs.
module laplacian_sharpen_3x3
    import lsh_pkg::*;
#(
    parameter int unsigned MAX_LINE_SAMPLES = MAX_LINE_SAMPLES_DEF,
    parameter int unsigned MAX_CHANNELS     = MAX_CHANNELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input beats
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_beat              i_in_data,
    // result beats
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_beat             o_out_data,
    // register writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned CH_W  = $clog2(MAX_CHANNELS + 1);
    localparam int unsigned LEN_W = $clog2(MAX_LINE_SAMPLES + 1);
    localparam int unsigned AW    = $clog2(MAX_LINE_SAMPLES);

    // Geometry from the register block.
    logic              cfg_clear;
    logic [CH_W-1:0]   eff_ch;
    logic [DIM_W-1:0]  eff_h;
    logic [LEN_W-1:0]  line_len;

    // Stage 0: read pointer into the line store, one step per accepted sample.
    logic [AW-1:0]     r_rd_ptr;

    // Stage 1: accepted beat, its line store address and read data.
    logic              r_s1_valid;
    t_in_beat          r_s1_beat;
    logic [AW-1:0]     r_s1_addr;
    t_line_word        line_rd;
    t_line_word        line_wr;

    // Result register.
    logic              r_out_valid;
    t_out_beat         r_out_data;

    logic              in_fire;
    logic              s1_fire;
    logic              s1_sample;
    logic              rd_en;
    t_emit_ctrl        emit_ctrl;
    logic [SAMPLE_W-1:0] k_value;
    logic [SAMPLE_W-1:0] k_centre;

    assign o_cfg_ready = 1'b1;

    lsh_cfg #(
        .MAX_LINE_SAMPLES (MAX_LINE_SAMPLES),
        .MAX_CHANNELS     (MAX_CHANNELS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_clear    (cfg_clear),
        .o_eff_ch   (eff_ch),
        .o_eff_h    (eff_h),
        .o_line_len (line_len)
    );

    // Stage 1 moves on whenever the result register is free or being emptied.
    assign s1_fire    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_fire;
    assign in_fire    = i_in_valid && o_in_ready;
    assign rd_en      = in_fire && (i_in_data.command == CMD_SAMPLE);
    assign s1_sample  = s1_fire && (r_s1_beat.command == CMD_SAMPLE);

    // Advance the pointer round one line; a write of any register rewinds it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_clear) begin
            r_rd_ptr <= '0;
        end else if (rd_en) begin
            if ((LEN_W'(r_rd_ptr) + LEN_W'(1)) >= line_len) begin
                r_rd_ptr <= '0;
            end else begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    // Hold the payload while stalled; load a fresh beat on acceptance.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_beat <= i_in_data;
            r_s1_addr <= r_rd_ptr;
        end
    end

    // Each entry carries the current sample one line on, and the window centre one line
    // on again, which becomes the upper neighbour two lines later.
    assign line_wr.fresh  = r_s1_beat.sample;
    assign line_wr.centre = k_centre;

    lsh_line_mem #(
        .DEPTH (MAX_LINE_SAMPLES)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (line_rd),
        .i_wr_en   (s1_sample),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (line_wr)
    );

    lsh_kernel #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_kernel (
        .i_clk    (i_clk),
        .i_shift  (s1_sample),
        .i_sample (r_s1_beat.sample),
        .i_line   (line_rd),
        .i_eff_ch (eff_ch),
        .o_value  (k_value),
        .o_centre (k_centre)
    );

    lsh_ctrl #(
        .MAX_LINE_SAMPLES (MAX_LINE_SAMPLES),
        .MAX_CHANNELS     (MAX_CHANNELS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (cfg_clear),
        .i_fire     (s1_fire),
        .i_command  (r_s1_beat.command),
        .i_eff_ch   (eff_ch),
        .i_eff_h    (eff_h),
        .i_line_len (line_len),
        .o_emit     (emit_ctrl)
    );

    // Result register: load on an emitting beat, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && emit_ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Border positions give zero.
    always_ff @(posedge i_clk) begin
        if (s1_fire && emit_ctrl.emit) begin
            r_out_data.result_value <= emit_ctrl.interior ? k_value : '0;
            r_out_data.frame_last   <= emit_ctrl.frame_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
